/* rtl/core/twf_pkg.sv */
`timescale 1ns / 1ps

package twf_pkg;

    // command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    // configuration register indexes
    localparam int unsigned CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CHARGE_THRESHOLD = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TARGET_ROW       = 2'd2;

    localparam logic [63:0] WINDOW_LENGTH_RST = 64'd100000000;

    // saturation limits of the record counters
    localparam logic [4:0]  RUN_MAX    = 5'd31;
    localparam logic [5:0]  PADCNT_MAX = 6'd63;
    localparam logic [20:0] SUM_MAX    = 21'h1FFFFF;

    typedef struct packed {
        logic [63:0] window_length;
        logic [15:0] charge_threshold;
        logic [2:0]  target_row;
    } t_cfg;

    // one queued command: optional record emit, then optional pad store write
    typedef struct packed {
        logic        emit;
        logic        we;
        logic [5:0]  pad;
        logic [15:0] charge;
        logic [63:0] stamp;
        logic [2:0]  row;
        logic [3:0]  section;
    } t_cmd;

    typedef struct packed {
        logic [QAW:0] count;
        logic         full;
        logic         empty;
    } t_q_stat;

    typedef struct packed {
        logic emit_fire;
        logic scanning;
    } t_bk_stat;

endpackage

/* rtl/core/twf_if.sv */
`timescale 1ns / 1ps

interface twf_hit_if;
    logic        valid;
    logic        ready;
    logic [63:0] hit_time;
    logic [5:0]  hit_pad;
    logic [2:0]  hit_row;
    logic [3:0]  hit_section;
    logic [15:0] hit_charge;

    modport source (output valid, hit_time, hit_pad, hit_row, hit_section, hit_charge,
                    input ready);
    modport sink   (input valid, hit_time, hit_pad, hit_row, hit_section, hit_charge,
                    output ready);
endinterface

interface twf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface twf_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  run_count;
    logic [5:0]  hit_pad_count;
    logic [20:0] charge_sum;
    logic [63:0] peak_time;
    logic [2:0]  out_row;
    logic [3:0]  out_section;

    modport source (output valid, run_count, hit_pad_count, charge_sum, peak_time,
                    out_row, out_section, input ready);
    modport sink   (input valid, run_count, hit_pad_count, charge_sum, peak_time,
                    out_row, out_section, output ready);
endinterface

/* rtl/core/time_window_pad_cluster_finder_core.sv */
`timescale 1ns / 1ps

// Time-window pad cluster finder.
// i_hit   : time-ordered hits (time, pad, row, section, charge); a transfer
//           happens when valid and ready are both high.
// i_cfg   : register writes (index 0 window length, 1 charge threshold,
//           2 target row); always ready, other indexes are dropped.
// o_res   : one cluster record per closed window that held a qualifying hit.
// Throughput: the front takes one hit per cycle while the 4-entry command
// queue has room. Each qualifying hit inside a window costs the back a
// pad store write; other in-window hits cost the back nothing.
// A closing hit that yields a record holds the back through the pop, a
// scan with one pad store read per cycle, a drain step for the registered
// read and an emit step that waits for the output register to free.
// Reset: clears window state, pad hit mask, queue and output valid; config
// returns to window length 1e8 ps, threshold 0, row 0. Store data is not
// cleared; the mask guards it.
// Stall: a record waits in the output register; the back then holds in its
// emit step, the queue fills, and i_hit.ready drops.

module time_window_pad_cluster_finder_core
    import twf_pkg::*;
#(
    parameter int PAD_STORE_DEPTH = 64,
    parameter int SCAN_PADS       = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    twf_hit_if.sink   i_hit,
    twf_cfg_if.sink   i_cfg,
    twf_res_if.source o_res
);

    t_cfg     r_cfg;
    t_cmd     f_cmd;
    logic     f_cmd_valid;
    logic     f_cmd_ready;
    t_cmd     b_cmd;
    logic     b_cmd_valid;
    logic     b_cmd_ready;
    t_q_stat  q_stat;
    t_bk_stat bk_stat;

    // config registers, to be written by the user only while idle; the block does not enforce this
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length    <= WINDOW_LENGTH_RST;
            r_cfg.charge_threshold <= '0;
            r_cfg.target_row       <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WINDOW_LENGTH:    r_cfg.window_length    <= i_cfg.data;
                CFG_CHARGE_THRESHOLD: r_cfg.charge_threshold <= i_cfg.data[15:0];
                CFG_TARGET_ROW:       r_cfg.target_row       <= i_cfg.data[2:0];
                default: begin
                end
            endcase
        end
    end

    // window tracking and qualification
    twf_front #(
        .PAD_STORE_DEPTH(PAD_STORE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hit       (i_hit),
        .i_cfg       (r_cfg),
        .o_cmd_valid (f_cmd_valid),
        .i_cmd_ready (f_cmd_ready),
        .o_cmd       (f_cmd)
    );

    twf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_cmd_valid),
        .o_push_ready (f_cmd_ready),
        .i_push_data  (f_cmd),
        .o_pop_valid  (b_cmd_valid),
        .i_pop_ready  (b_cmd_ready),
        .o_pop_data   (b_cmd),
        .o_stat       (q_stat)
    );

    // pad store, scan and record output
    twf_back #(
        .PAD_STORE_DEPTH(PAD_STORE_DEPTH),
        .SCAN_PADS      (SCAN_PADS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (b_cmd_valid),
        .o_cmd_ready (b_cmd_ready),
        .i_cmd       (b_cmd),
        .o_res       (o_res),
        .o_stat      (bk_stat)
    );

    // record valid drops during reset
    a_rst_no_rec: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("record valid after reset");

    // a new record only comes out of the back's emit step
    a_rec_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !$past(o_res.valid)) |-> $past(bk_stat.emit_fire))
        else $error("record without emit");

    // queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= (QAW+1)'(QDEPTH))
        else $error("command queue overflow");

    // no command is popped while a scan runs
    a_no_pop_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_stat.scanning |-> !b_cmd_ready)
        else $error("pop during scan");

endmodule

/* rtl/core/twf_front.sv */
`timescale 1ns / 1ps

module twf_front
    import twf_pkg::*;
#(
    parameter int PAD_STORE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twf_hit_if.sink    i_hit,
    input  t_cfg       i_cfg,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);

    logic [63:0] r_ws, n_ws;
    logic        r_started, n_started;
    logic        r_has_hit, n_has_hit;

    logic [63:0] ws_eff;
    logic [63:0] diff;
    logic        in_win;
    logic        qual;
    logic        emit;
    logic        acc;

    assign i_hit.ready = i_cmd_ready;
    assign acc         = i_hit.valid && i_cmd_ready;

    always_comb begin
        ws_eff = r_started ? r_ws : i_hit.hit_time;
        diff   = i_hit.hit_time - ws_eff;
        in_win = diff < i_cfg.window_length;
        qual   = (i_hit.hit_row == i_cfg.target_row)
              && (i_hit.hit_charge > i_cfg.charge_threshold)
              && (32'(i_hit.hit_pad) < 32'(PAD_STORE_DEPTH));
        emit   = !in_win && r_has_hit;
    end

    always_comb begin
        o_cmd_valid   = i_hit.valid && (emit || qual);
        o_cmd.emit    = emit;
        o_cmd.we      = qual;
        o_cmd.pad     = i_hit.hit_pad;
        o_cmd.charge  = i_hit.hit_charge;
        o_cmd.stamp   = i_hit.hit_time;
        o_cmd.row     = i_hit.hit_row;
        o_cmd.section = i_hit.hit_section;
    end

    always_comb begin
        n_ws      = r_ws;
        n_started = r_started;
        n_has_hit = r_has_hit;
        if (acc) begin
            n_started = 1'b1;
            if (!in_win) begin
                n_ws      = i_hit.hit_time;
                n_has_hit = qual;
            end else begin
                n_ws      = ws_eff;
                n_has_hit = r_has_hit || qual;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= '0;
            r_started <= 1'b0;
            r_has_hit <= 1'b0;
        end else begin
            r_ws      <= n_ws;
            r_started <= n_started;
            r_has_hit <= n_has_hit;
        end
    end

endmodule

/* rtl/core/twf_queue.sv */
`timescale 1ns / 1ps

module twf_queue
    import twf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_cmd    i_push_data,
    output logic    o_pop_valid,
    input  logic    i_pop_ready,
    output t_cmd    o_pop_data,
    output t_q_stat o_stat
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    assign o_stat.count = r_cnt;
    assign o_stat.full  = !o_push_ready;
    assign o_stat.empty = !o_pop_valid;

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/core/twf_back.sv */
`timescale 1ns / 1ps

module twf_back
    import twf_pkg::*;
#(
    parameter int PAD_STORE_DEPTH = 64,
    parameter int SCAN_PADS       = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    output logic     o_cmd_ready,
    input  t_cmd     i_cmd,
    twf_res_if.source o_res,
    output t_bk_stat o_stat
);

    localparam int AW = $clog2(PAD_STORE_DEPTH);
    localparam int IW = (SCAN_PADS > 1) ? $clog2(SCAN_PADS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SCAN_PADS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // pad store
    logic [PAD_STORE_DEPTH-1:0] r_mask, n_mask;
    logic [15:0] r_mem_q [PAD_STORE_DEPTH];
    logic [63:0] r_mem_t [PAD_STORE_DEPTH];

    // scan read stage
    logic [IW-1:0] r_idx, n_idx;
    logic          r_rd_vld, n_rd_vld;
    logic          r_rd_hit, n_rd_hit;
    logic [15:0]   r_rd_q;
    logic [63:0]   r_rd_t;
    logic [AW-1:0] rd_addr;
    logic          in_store;
    logic          rd_en;

    // record accumulators
    logic [4:0]  r_runs, n_runs;
    logic [5:0]  r_cnt, n_cnt;
    logic [20:0] r_sum, n_sum;
    logic [15:0] r_best, n_best;
    logic [63:0] r_peak, n_peak;
    logic        r_prev, n_prev;
    logic [21:0] sum_w;

    t_cmd r_cmd, n_cmd;

    // write port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_q;
    logic [63:0]   wr_t;

    logic pop;
    logic out_free;
    logic emit_fire;

    // output register
    logic        r_out_vld, n_out_vld;
    logic [4:0]  r_o_runs;
    logic [5:0]  r_o_cnt;
    logic [20:0] r_o_sum;
    logic [63:0] r_o_peak;
    logic [2:0]  r_o_row;
    logic [3:0]  r_o_sec;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign out_free    = !r_out_vld || o_res.ready;
    assign emit_fire   = (r_state == S_EMIT) && out_free;

    assign o_stat.emit_fire = emit_fire;
    assign o_stat.scanning  = (r_state == S_SCAN) || (r_state == S_DRAIN);

    assign in_store = 32'(r_idx) < 32'(PAD_STORE_DEPTH);
    assign rd_addr  = AW'(32'(r_idx));
    assign rd_en    = (r_state == S_SCAN);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cmd   = r_cmd;
        wr_en   = 1'b0;
        wr_addr = AW'(i_cmd.pad);
        wr_q    = i_cmd.charge;
        wr_t    = i_cmd.stamp;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    if (i_cmd.emit) begin
                        n_cmd   = i_cmd;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else begin
                        wr_en = i_cmd.we;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // closing hit lands in the fresh window after the record leaves
                wr_addr = AW'(r_cmd.pad);
                wr_q    = r_cmd.charge;
                wr_t    = r_cmd.stamp;
                if (out_free) begin
                    wr_en   = r_cmd.we;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_mask = r_mask;
        if (emit_fire) begin
            n_mask = '0;
        end
        if (wr_en) begin
            n_mask[wr_addr] = 1'b1;
        end
    end

    assign n_rd_vld = rd_en;
    assign n_rd_hit = rd_en && in_store && r_mask[rd_addr];

    // one pad per cycle into the record
    always_comb begin
        n_runs = r_runs;
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_best = r_best;
        n_peak = r_peak;
        n_prev = r_prev;
        sum_w  = {1'b0, r_sum} + {6'd0, r_rd_q};
        if (pop && i_cmd.emit) begin
            n_runs = '0;
            n_cnt  = '0;
            n_sum  = '0;
            n_best = '0;
            n_peak = '0;
            n_prev = 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd_hit) begin
                if (!r_prev && r_runs != RUN_MAX) begin
                    n_runs = r_runs + 1'b1;
                end
                if (r_cnt != PADCNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_sum = sum_w[21] ? SUM_MAX : sum_w[20:0];
                if (r_rd_q > r_best) begin
                    n_best = r_rd_q;
                    n_peak = r_rd_t;
                end
            end
            n_prev = r_rd_hit;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (emit_fire) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_q[wr_addr] <= wr_q;
            r_mem_t[wr_addr] <= wr_t;
        end
        if (rd_en) begin
            r_rd_q <= r_mem_q[rd_addr];
            r_rd_t <= r_mem_t[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_runs <= n_runs;
        r_cnt  <= n_cnt;
        r_sum  <= n_sum;
        r_best <= n_best;
        r_peak <= n_peak;
        r_prev <= n_prev;
        r_rd_hit <= n_rd_hit;
        if (emit_fire) begin
            r_o_runs <= r_runs;
            r_o_cnt  <= r_cnt;
            r_o_sum  <= r_sum;
            r_o_peak <= r_peak;
            r_o_row  <= r_cmd.row;
            r_o_sec  <= r_cmd.section;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mask    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mask    <= n_mask;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.run_count     = r_o_runs;
    assign o_res.hit_pad_count = r_o_cnt;
    assign o_res.charge_sum    = r_o_sum;
    assign o_res.peak_time     = r_o_peak;
    assign o_res.out_row       = r_o_row;
    assign o_res.out_section   = r_o_sec;

endmodule

/* sim/tb_time_window_pad_cluster_finder_core.sv */
`timescale 1ns / 1ps

// Cluster finder bench: directed hits walk the window edges, then random
// hit streams run under several register settings while both handshakes
// stall at random. A scoreboard predicts every record from accepted hits.
module tb_time_window_pad_cluster_finder_core;
    import twf_pkg::*;

    localparam int PAD_DEPTH    = 64;
    localparam int SCAN_COUNT   = 32;
    // margin for the back to finish a record scan; allow queued commands too
    localparam int SETTLE_CYCLES = 2 * (SCAN_COUNT + 8);
    localparam int LONG_HOLD    = 400;
    localparam int NUM_PHASES   = 9;
    // index that no register answers to; writes there must be dropped
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [63:0] stamp;
        logic [5:0]  pad;
        logic [2:0]  row;
        logic [3:0]  section;
        logic [15:0] charge;
    } t_hit_item;

    typedef struct packed {
        logic [4:0]  runs;
        logic [5:0]  pads;
        logic [20:0] sum;
        logic [63:0] peak;
        logic [2:0]  row;
        logic [3:0]  section;
    } t_cluster_rec;

    // Window tracking and pad store copy; records queue up at window close.
    class cluster_scoreboard;
        logic [63:0]          win_len;
        logic [15:0]          thresh;
        logic [2:0]           trow;
        logic [63:0]          win_start;
        bit                   started;
        bit                   has_hit;
        logic [PAD_DEPTH-1:0] pad_mask;
        logic [15:0]          pad_charge [PAD_DEPTH];
        logic [63:0]          pad_stamp  [PAD_DEPTH];
        t_cluster_rec         expected_records [$];
        int                   errors;

        function new();
            win_len   = WINDOW_LENGTH_RST;
            thresh    = '0;
            trow      = '0;
            win_start = '0;
            started   = 1'b0;
            has_hit   = 1'b0;
            pad_mask  = '0;
            errors    = 0;
        endfunction

        function void write_register(logic [CFG_IW-1:0] idx, logic [63:0] val);
            case (idx)
                CFG_WINDOW_LENGTH:    win_len = val;
                CFG_CHARGE_THRESHOLD: thresh  = val[15:0];
                CFG_TARGET_ROW:       trow    = val[2:0];
                default: ;
            endcase
        endfunction

        function void store_if_qualifying(t_hit_item h);
            if (h.row != trow || h.charge <= thresh || int'(h.pad) >= PAD_DEPTH) return;
            pad_mask[h.pad]   = 1'b1;
            pad_charge[h.pad] = h.charge;
            pad_stamp[h.pad]  = h.stamp;
            has_hit           = 1'b1;
        endfunction

        function t_cluster_rec scan_cluster(t_hit_item closer);
            t_cluster_rec r;
            int unsigned  runs;
            int unsigned  cnt;
            int unsigned  sum;
            logic [15:0]  best;
            logic [63:0]  peak;
            bit           prev;
            bit           here;
            runs = 0;
            cnt  = 0;
            sum  = 0;
            best = '0;
            peak = '0;
            prev = 1'b0;
            for (int j = 0; j < SCAN_COUNT; j++) begin
                here = (j < PAD_DEPTH) && pad_mask[j];
                if (here) begin
                    if (!prev && runs < RUN_MAX) runs++;
                    if (cnt < PADCNT_MAX) cnt++;
                    sum += pad_charge[j];
                    if (sum > SUM_MAX) sum = SUM_MAX;
                    if (pad_charge[j] > best) begin
                        best = pad_charge[j];
                        peak = pad_stamp[j];
                    end
                end
                prev = here;
            end
            r.runs    = runs[4:0];
            r.pads    = cnt[5:0];
            r.sum     = sum[20:0];
            r.peak    = peak;
            r.row     = closer.row;
            r.section = closer.section;
            return r;
        endfunction

        function void note_hit(t_hit_item h);
            logic [63:0] diff;
            if (!started) begin
                started   = 1'b1;
                win_start = h.stamp;
            end
            diff = h.stamp - win_start;
            if (diff < win_len) begin
                store_if_qualifying(h);
                return;
            end
            if (has_hit) expected_records.push_back(scan_cluster(h));
            pad_mask  = '0;
            has_hit   = 1'b0;
            win_start = h.stamp;
            store_if_qualifying(h);
        endfunction

        function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
            if (exp_val !== act_val) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_record(t_cluster_rec got);
            t_cluster_rec want;
            if (expected_records.size() == 0) begin
                errors++;
                $display("%0t: unexpected record, expected none, actual %h", $time, got);
                return;
            end
            want = expected_records.pop_front();
            compare_field("run_count",     want.runs,    got.runs);
            compare_field("hit_pad_count", want.pads,    got.pads);
            compare_field("charge_sum",    want.sum,     got.sum);
            compare_field("peak_time",     want.peak,    got.peak);
            compare_field("out_row",       want.row,     got.row);
            compare_field("out_section",   want.section, got.section);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    twf_hit_if hit_bus ();
    twf_cfg_if cfg_bus ();
    twf_res_if res_bus ();

    time_window_pad_cluster_finder_core #(
        .PAD_STORE_DEPTH (PAD_DEPTH),
        .SCAN_PADS       (SCAN_COUNT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hit   (hit_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    cluster_scoreboard sb = new();

    // the first two are shared between the sender and the result-side process
    bit          long_hold_req = 1'b0;
    bit          quiet = 1'b0;
    logic [63:0] cur_time = '0;
    logic [5:0]  last_pad = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: every record transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            sb.check_record({res_bus.run_count, res_bus.hit_pad_count, res_bus.charge_sum,
                             res_bus.peak_time, res_bus.out_row, res_bus.out_section});
        end
    end

    // result ready: random stall bursts, one long hold-off on request,
    // always ready in the quiet tail
    initial begin
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (quiet) begin
                res_bus.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic t_hit_item mk_hit(logic [63:0] stamp, logic [5:0] pad, logic [2:0] row,
                                         logic [3:0] section, logic [15:0] charge);
        t_hit_item h;
        h.stamp   = stamp;
        h.pad     = pad;
        h.row     = row;
        h.section = section;
        h.charge  = charge;
        return h;
    endfunction

    // Random hit: mostly small steps inside the window, some exact window
    // edges, some jumps past it, a few steps back in time.
    function automatic t_hit_item next_random_hit();
        t_hit_item   h;
        int unsigned r;
        logic [63:0] span;
        logic [63:0] off;
        r    = $urandom_range(0, 99);
        span = (sb.win_len >> 3) + 64'd1;
        if (r < 4) begin
            cur_time = cur_time - $urandom_range(1, 1000);
        end else if (r < 8) begin
            cur_time = sb.win_start + sb.win_len - 64'd1;
        end else if (r < 12) begin
            cur_time = sb.win_start + sb.win_len;
        end else if (r < 24) begin
            off = sb.win_len;
            if (off <= 64'hFFFF_FFFF_FFFF_FFFF - 64'd5000) off = off + $urandom_range(0, 5000);
            cur_time = sb.win_start + off;
        end else begin
            cur_time = cur_time + ({$urandom, $urandom} % span);
        end
        h.stamp = cur_time;

        r = $urandom_range(0, 99);
        if (r < 15)      h.pad = 6'($urandom_range(32, 63));
        else if (r < 55) h.pad = (last_pad + 6'($urandom_range(0, 2))) & 6'd31;
        else             h.pad = 6'($urandom_range(0, 31));
        last_pad = h.pad;

        h.row     = ($urandom_range(0, 3) != 0) ? sb.trow : 3'($urandom);
        h.section = 4'($urandom);

        // bias charges around the threshold so both sides of it show up
        r = $urandom_range(0, 99);
        if (r < 20)      h.charge = (sb.thresh == 16'hFFFF) ? 16'hFFFF : sb.thresh + 16'd1;
        else if (r < 30) h.charge = sb.thresh;
        else if (r < 40) h.charge = 16'hFFFF;
        else if (r < 45) h.charge = 16'h0000;
        else             h.charge = 16'($urandom);
        return h;
    endfunction

    // holds valid high on return so back-to-back hits need no re-raise
    task automatic send_hit(t_hit_item h);
        hit_bus.valid       <= 1'b1;
        hit_bus.hit_time    <= h.stamp;
        hit_bus.hit_pad     <= h.pad;
        hit_bus.hit_row     <= h.row;
        hit_bus.hit_section <= h.section;
        hit_bus.hit_charge  <= h.charge;
        do @(posedge i_clk); while (hit_bus.ready !== 1'b1);
        sb.note_hit(h);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [63:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        sb.write_register(idx, val);
    endtask

    // upper threshold and row data bits are random: the block must ignore them
    task automatic program_regs(logic [63:0] wl, logic [15:0] thr, logic [2:0] row,
                                bit with_unused);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_reg(CFG_WINDOW_LENGTH, wl);
        write_reg(CFG_CHARGE_THRESHOLD, {noise[63:16], thr});
        write_reg(CFG_TARGET_ROW, {noise[63:3], row});
        if (with_unused) write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every predicted record is out, then let
    // queued non-record commands retire before touching registers
    task automatic wait_idle();
        hit_bus.valid <= 1'b0;
        while (sb.expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] ph_wl;
        logic [15:0] ph_thr;
        logic [2:0]  ph_row;
        int          ph_items;

        i_rst_n             <= 1'b0;
        hit_bus.valid       <= 1'b0;
        hit_bus.hit_time    <= '0;
        hit_bus.hit_pad     <= '0;
        hit_bus.hit_row     <= '0;
        hit_bus.hit_section <= '0;
        hit_bus.hit_charge  <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= '0;
        cfg_bus.data        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: window edges, overwrite, ties, wrong row, far pads ----
        program_regs(64'd100, 16'd0, 3'd0, 1'b1);
        send_hit(mk_hit(64'd1000, 6'd0,  3'd0, 4'd0,  16'd0));     // opens window, charge at threshold
        send_hit(mk_hit(64'd1000, 6'd0,  3'd0, 4'd3,  16'd1));
        send_hit(mk_hit(64'd1010, 6'd1,  3'd0, 4'd15, 16'hFFFF));
        send_hit(mk_hit(64'd1020, 6'd1,  3'd0, 4'd1,  16'd5));     // overwrites pad 1
        send_hit(mk_hit(64'd1030, 6'd3,  3'd0, 4'd2,  16'd5));     // ties pad 1, lower pad wins
        send_hit(mk_hit(64'd1040, 6'd2,  3'd7, 4'd4,  16'd100));   // wrong row
        send_hit(mk_hit(64'd1099, 6'd31, 3'd0, 4'd5,  16'd5));     // last inside
        send_hit(mk_hit(64'd1100, 6'd5,  3'd7, 4'd15, 16'd9));     // first outside closes
        send_hit(mk_hit(64'd1150, 6'd40, 3'd0, 4'd6,  16'd300));   // qualifies, not scanned
        send_hit(mk_hit(64'd1199, 6'd63, 3'd0, 4'd7,  16'hFFFF));
        send_hit(mk_hit(64'd1300, 6'd0,  3'd0, 4'd8,  16'd7));     // empty-scan record
        send_hit(mk_hit(64'd1250, 6'd2,  3'd0, 4'd9,  16'd8));     // time goes back
        send_hit(mk_hit(64'd2000, 6'd4,  3'd0, 4'd10, 16'd1));
        wait_idle();

        // zero length: every hit closes; threshold at its top but one
        program_regs(64'd0, 16'hFFFE, 3'd7, 1'b0);
        send_hit(mk_hit(64'd5000, 6'd10, 3'd7, 4'd1,  16'hFFFF));
        send_hit(mk_hit(64'd5000, 6'd11, 3'd7, 4'd2,  16'hFFFF));
        send_hit(mk_hit(64'd5000, 6'd12, 3'd7, 4'd3,  16'hFFFE));
        send_hit(mk_hit(64'd5001, 6'd13, 3'd7, 4'd4,  16'hFFFF));
        wait_idle();

        // maximal length: only a step back of exactly one closes
        program_regs(64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 3'd7, 1'b0);
        send_hit(mk_hit(64'hFFFF_FFFF_FFFF_FFF0, 6'd0,  3'd7, 4'd0,  16'd2));
        send_hit(mk_hit(64'hFFFF_FFFF_FFFF_FFFF, 6'd31, 3'd7, 4'd5,  16'd3));
        send_hit(mk_hit(64'd5,                   6'd32, 3'd7, 4'd6,  16'd4));
        send_hit(mk_hit(64'd5000,                6'd30, 3'd7, 4'd9,  16'd1));
        cur_time = 64'd5000;

        // ---- random phases ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin ph_wl = 64'd100;                 ph_thr = 16'd0;     ph_row = 3'd0; ph_items = 140; end
                1: begin ph_wl = 64'd1;                   ph_thr = 16'd100;   ph_row = 3'd3; ph_items = 140; end
                2: begin ph_wl = 64'd1;                   ph_thr = 16'hFFFF;  ph_row = 3'd0; ph_items = 40;  end
                3: begin ph_wl = 64'd1000;                ph_thr = 16'd40000; ph_row = 3'd7; ph_items = 130; end
                4: begin ph_wl = WINDOW_LENGTH_RST;       ph_thr = 16'd0;     ph_row = 3'd5; ph_items = 140; end
                5: begin ph_wl = 64'h0000_0100_0000_0000; ph_thr = 16'hFFFE;  ph_row = 3'd1; ph_items = 130; end
                6: begin ph_wl = 64'hFFFF_FFFF_FFFF_FFFF; ph_thr = 16'd20;    ph_row = 3'd2; ph_items = 130; end
                7: begin ph_wl = 64'd37;                  ph_thr = 16'd1;     ph_row = 3'd4; ph_items = 140; end
                default: begin
                    ph_wl = 64'd5000; ph_thr = 16'd30000; ph_row = 3'd6; ph_items = 130;
                end
            endcase
            wait_idle();
            program_regs(ph_wl, ph_thr, ph_row, 1'b0);
            // jump to a random spot now and then so the high time bits toggle
            if (p % 3 == 2) cur_time = {$urandom, $urandom};
            quiet = (p == NUM_PHASES - 1);
            // receiver holds off while hits keep coming: queue fills, input stalls
            if (p == 1) long_hold_req = 1'b1;
            for (int k = 0; k < ph_items; k++) begin
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    hit_bus.valid <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge i_clk);
                end
                send_hit(next_random_hit());
            end
        end
        wait_idle();

        if (sb.errors == 0 && sb.expected_records.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/twf_pkg.sv
rtl/core/twf_if.sv
rtl/core/twf_front.sv
rtl/core/twf_queue.sv
rtl/core/twf_back.sv
rtl/core/time_window_pad_cluster_finder_core.sv
sim/tb_time_window_pad_cluster_finder_core.sv
